### hdl/rsw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared types and constants of the rotating, shifting, row-wrapping
// Hermite spline resampler.
// ----------------------------------------------------------------------------
package rsw_pkg;

	localparam int IMG_ROWS_DEF     = 256;
	localparam int IMG_COLS_DEF     = 256;
	localparam int SAMPLE_WIDTH_DEF = 32;

	localparam int STORE_DEPTH = 65536;
	localparam int STORE_AW    = 16;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 28;

	localparam logic [CFG_IW-1:0] CFG_ROT_SIN  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ROT_COS  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_SHIFT_X  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_SHIFT_Y  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_WRAP_ROW = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_OUT_ROWS = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_OUT_COLS = 3'd6;

	// reads per output pixel: four columns, two rows
	localparam int RD_CNT = 8;
	localparam int FDEPTH = 4;

	typedef enum logic [1:0] {
		CMD_IMG = 2'd0,
		CMD_GRD = 2'd1,
		CMD_PIX = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef struct packed {
		logic signed [20:0] rot_sin;
		logic signed [20:0] rot_cos;
		logic signed [27:0] shift_x;
		logic signed [27:0] shift_y;
		logic [8:0]         wrap_row;
		logic [10:0]        out_rows;
		logic [10:0]        out_cols;
	} cfg_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [15:0]        addr;
		logic signed [31:0] accum;
	} pay_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [15:0]        addr;
		logic signed [31:0] accum;
		logic               ok;
		logic               v0;
		logic               v3;
		logic [15:0]        xm;
		logic [15:0]        ym;
		logic [15:0]        base1;
		logic [15:0]        base2;
	} item_t;

	typedef struct packed {
		logic signed [31:0] accum;
		logic               ok;
		logic               v0;
		logic               v3;
		logic [15:0]        xm;
	} side_t;

endpackage
`default_nettype wire

### hdl/rsw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rsw_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [W-1:0]             wdata,
	output logic [W-1:0]                  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

### hdl/rsw_herm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_herm
// Pipelined cubic Hermite spline evaluator, one evaluation per cycle, with a
// tag carried alongside.
// ----------------------------------------------------------------------------
module rsw_herm #(
	parameter int VW = 32,
	parameter int TW = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic signed [VW-1:0] y1,
	input  wire logic signed [VW-1:0] y2,
	input  wire logic signed [VW-1:0] k1,
	input  wire logic signed [VW-1:0] k2,
	input  wire logic [15:0]          t,
	input  wire logic [TW-1:0]        tag_in,
	output logic                      out_valid,
	output logic signed [VW+1:0]      value,
	output logic [TW-1:0]             tag_out
);
	localparam int AW = VW + 2;
	localparam int PW = VW + 20;
	localparam int MW = AW + 17;

	logic signed [AW-1:0] d_c, a_c, b_c;
	logic [16:0]          u_c;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [TW-1:0]        tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [VW-1:0] y1_s1, y2_s1;
	logic signed [AW-1:0] a_s1, b_s1;
	logic [15:0]          t_s1;
	logic [16:0]          u_s1;

	logic signed [PW-1:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic [32:0]          tu_s2;

	logic signed [PW-1:0] lsum_c, isum_c, lsh_c, ish_c;
	logic signed [VW:0]   lin_s3, lin_s4;
	logic signed [AW-1:0] inn_s3;
	logic [15:0]          tt_s3;

	logic signed [MW-1:0] m_s4, msh_c;

	assign u_c = 17'd65536 - {1'b0, t};
	assign d_c = AW'(y2) - AW'(y1);
	assign a_c = AW'(k1) - d_c;
	assign b_c = d_c - AW'(k2);

	assign lsum_c = m1_s2 + m2_s2;
	assign isum_c = m3_s2 + m4_s2;
	assign lsh_c  = lsum_c >>> 16;
	assign ish_c  = isum_c >>> 16;
	assign msh_c  = m_s4 >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		y1_s1  <= y1;
		y2_s1  <= y2;
		a_s1   <= a_c;
		b_s1   <= b_c;
		t_s1   <= t;
		u_s1   <= u_c;
		tag_s1 <= tag_in;

		m1_s2  <= y1_s1 * $signed({1'b0, u_s1});
		m2_s2  <= y2_s1 * $signed({1'b0, t_s1});
		m3_s2  <= a_s1 * $signed({1'b0, u_s1});
		m4_s2  <= b_s1 * $signed({1'b0, t_s1});
		tu_s2  <= 33'(t_s1) * 33'(u_s1);
		tag_s2 <= tag_s1;

		lin_s3 <= lsh_c[VW:0];
		inn_s3 <= ish_c[AW-1:0];
		tt_s3  <= tu_s2[31:16];
		tag_s3 <= tag_s2;

		m_s4   <= inn_s3 * $signed({1'b0, tt_s3});
		lin_s4 <= lin_s3;
		tag_s4 <= tag_s3;

		value   <= (VW+2)'(lin_s4) + (VW+2)'(msh_c);
		tag_out <= tag_s4;
	end
endmodule
`default_nettype wire

### hdl/rsw_coord.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsw_coord
// Elastic five-stage front end: sample saturation, coordinate rotation,
// shift and row wrap, range checks and store base addresses.
// ----------------------------------------------------------------------------
module rsw_coord #(
	parameter int IMG_ROWS     = 256,
	parameter int IMG_COLS     = 256,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rsw_pkg::cfg_t        cfg,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic [15:0]          sample_addr,
	input  wire logic signed [31:0]   sample_value,
	input  wire logic [9:0]           pixel_row,
	input  wire logic [9:0]           pixel_col,
	input  wire logic signed [31:0]   accum_in,
	output logic                      out_valid,
	output rsw_pkg::item_t            out_item,
	output logic [SAMPLE_WIDTH-1:0]   out_wdata,
	input  wire logic                 take
);
	import rsw_pkg::*;

	localparam int XW = 38;
	localparam int CW = XW - 16;
	localparam int RB = (IMG_ROWS > 1) ? $clog2(IMG_ROWS) : 1;
	localparam logic signed [XW-1:0] XOFF = XW'(IMG_COLS * 32768 - 32768);
	localparam logic signed [XW-1:0] YOFF = XW'(IMG_ROWS * 32768 - 32768);

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	pay_t pay_s1, pay_s2, pay_s3, pay_s4, pay_s5;
	logic [SAMPLE_WIDTH-1:0] wd_c, wd_s1, wd_s2, wd_s3, wd_s4, wd_s5;

	logic signed [12:0] nx_c, ny_c, nx_s1, ny_s1;
	logic signed [33:0] pcx_s2, psy_s2, pcy_s2, psx_s2;
	logic signed [34:0] xsum_c, ysum_c, xh_c, yh_c;
	logic signed [XW-1:0] xs_c, ys_c, xs_s3, ys_s3, xsh_c, ysh_c;
	logic signed [CW-1:0] x1_c, r1_c, r1w_c, x1m_c;
	logic ok_c, v0_c, v3_c;
	logic ok_s4, v0_s4, v3_s4, ok_s5, v0_s5, v3_s5;
	logic [15:0] xm_s4, ym_s4, x1m_s4, xm_s5, ym_s5;
	logic [RB-1:0] r1_s4, r2_s4;
	logic [31:0] b1_c, b2_c;
	logic [15:0] base1_s5, base2_s5;

	generate
		if (SAMPLE_WIDTH < 32) begin : g_sat
			localparam int SMAX = (1 << (SAMPLE_WIDTH - 1)) - 1;
			localparam int SMIN = -(1 << (SAMPLE_WIDTH - 1));
			always_comb begin
				if (sample_value > SMAX) begin
					wd_c = SAMPLE_WIDTH'(SMAX);
				end else if (sample_value < SMIN) begin
					wd_c = SAMPLE_WIDTH'(SMIN);
				end else begin
					wd_c = SAMPLE_WIDTH'(sample_value);
				end
			end
		end else begin : g_ext
			assign wd_c = SAMPLE_WIDTH'(sample_value);
		end
	endgenerate

	assign rdy5 = !v_s5 || take;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign nx_c = $signed({2'b00, pixel_col, 1'b1}) - $signed({2'b00, cfg.out_cols});
	assign ny_c = $signed({2'b00, pixel_row, 1'b1}) - $signed({2'b00, cfg.out_rows});

	assign xsum_c = 35'(pcx_s2) + 35'(psy_s2);
	assign ysum_c = 35'(pcy_s2) - 35'(psx_s2);
	assign xh_c   = xsum_c >>> 1;
	assign yh_c   = ysum_c >>> 1;
	assign xs_c   = XW'(xh_c) + XOFF - XW'(cfg.shift_x);
	assign ys_c   = XW'(yh_c) + YOFF - XW'(cfg.shift_y)
	                + $signed(XW'({cfg.wrap_row, 16'd0}));

	assign xsh_c = xs_s3 >>> 16;
	assign ysh_c = ys_s3 >>> 16;
	assign x1_c  = xsh_c[CW-1:0];
	assign r1_c  = ysh_c[CW-1:0];
	assign r1w_c = (r1_c >= IMG_ROWS) ? r1_c - CW'(IMG_ROWS) : r1_c;
	assign x1m_c = x1_c - CW'(1);
	assign ok_c  = (r1w_c >= 0) && (r1w_c < IMG_ROWS) && (x1_c >= 0) &&
	               (x1_c + 1 < IMG_COLS);
	assign v0_c  = (x1_c != 0);
	assign v3_c  = (x1_c + 2 < IMG_COLS);

	assign b1_c = 32'(r1_s4) * 32'(IMG_COLS) + 32'(x1m_s4);
	assign b2_c = 32'(r2_s4) * 32'(IMG_COLS) + 32'(x1m_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			pay_s1 <= '{cmd: cmd_t'(cmd), addr: sample_addr, accum: accum_in};
			wd_s1  <= wd_c;
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
		end
		if (rdy2 && v_s1) begin
			pay_s2 <= pay_s1;
			wd_s2  <= wd_s1;
			pcx_s2 <= cfg.rot_cos * nx_s1;
			psy_s2 <= cfg.rot_sin * ny_s1;
			pcy_s2 <= cfg.rot_cos * ny_s1;
			psx_s2 <= cfg.rot_sin * nx_s1;
		end
		if (rdy3 && v_s2) begin
			pay_s3 <= pay_s2;
			wd_s3  <= wd_s2;
			xs_s3  <= xs_c;
			ys_s3  <= ys_c;
		end
		if (rdy4 && v_s3) begin
			pay_s4 <= pay_s3;
			wd_s4  <= wd_s3;
			ok_s4  <= ok_c;
			v0_s4  <= v0_c;
			v3_s4  <= v3_c;
			xm_s4  <= xs_s3[15:0];
			ym_s4  <= ys_s3[15:0];
			x1m_s4 <= x1m_c[15:0];
			r1_s4  <= r1w_c[RB-1:0];
			r2_s4  <= (r1w_c == IMG_ROWS - 1) ? '0 : RB'(r1w_c + CW'(1));
		end
		if (rdy5 && v_s4) begin
			pay_s5   <= pay_s4;
			wd_s5    <= wd_s4;
			ok_s5    <= ok_s4;
			v0_s5    <= v0_s4;
			v3_s5    <= v3_s4;
			xm_s5    <= xm_s4;
			ym_s5    <= ym_s4;
			base1_s5 <= b1_c[15:0];
			base2_s5 <= b2_c[15:0];
		end
	end

	assign out_valid = v_s5;
	assign out_wdata = wd_s5;
	assign out_item  = '{cmd: pay_s5.cmd, addr: pay_s5.addr, accum: pay_s5.accum,
	                     ok: ok_s5, v0: v0_s5, v3: v3_s5, xm: xm_s5, ym: ym_s5,
	                     base1: base1_s5, base2: base2_s5};
endmodule
`default_nettype wire

### hdl/rotate_shift_wrap_spline_interp_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_shift_wrap_spline_interp_top
// Rotated, shifted, row-wrapped Hermite spline resampler over an image and
// its row gradients held in two single-port RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall) carries one command per transaction:
//   image write, gradient write, pixel compute or no-op. A write is a single
//   access at the RAM port. A compute issues eight reads to each RAM (four
//   columns by two rows), one per cycle once a buffer slot is free, so the
//   single RAM port bounds the sustained pixel throughput. Writes and
//   computes pass the RAMs in request order.
//   rsp channel (rsp_valid/rsp_stall) returns one transaction per compute.
//   Results queue in a four-entry output buffer; a compute only starts its
//   reads when a buffer slot is free, so a stalled receiver backs up into
//   req_stall without losing anything.
//   cfg channel writes the registers at any time the block is idle; it is
//   always ready.
//   Reset clears the pipeline, the queue and the registers to their defaults;
//   the RAM contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module rotate_shift_wrap_spline_interp_top #(
	parameter int IMG_ROWS     = rsw_pkg::IMG_ROWS_DEF,
	parameter int IMG_COLS     = rsw_pkg::IMG_COLS_DEF,
	parameter int SAMPLE_WIDTH = rsw_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [rsw_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [rsw_pkg::CFG_DW-1:0]  cfg_data,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic [1:0]                  cmd,
	input  wire logic [15:0]                 sample_addr,
	input  wire logic signed [31:0]          sample_value,
	input  wire logic [9:0]                  pixel_row,
	input  wire logic [9:0]                  pixel_col,
	input  wire logic signed [31:0]          accum_in,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic signed [31:0]               pixel_sum,
	output logic                             in_range
);
	import rsw_pkg::*;

	localparam int SB  = $bits(side_t);
	localparam int YTW = SB + 2;
	localparam int FPW = $clog2(FDEPTH);
	localparam int FCW = $clog2(FDEPTH + 1);
	localparam logic [2:0] RD_LAST = 3'(RD_CNT - 1);
	localparam logic signed [37:0] SUM_MAX = 38'sd2147483647;
	localparam logic signed [37:0] SUM_MIN = -38'sd2147483648;

	cfg_t cfg_q;

	logic                    it_v, take;
	item_t                   it;
	logic [SAMPLE_WIDTH-1:0] it_wd;

	logic [2:0]  cnt_q;
	logic        is_pix, credit, issue, we_img, we_grd;
	logic [15:0] raddr_c, img_addr, grd_addr;
	logic [SAMPLE_WIDTH-1:0] img_rdata, grd_rdata;
	logic signed [31:0] img_rd, grd_rd;

	logic        rd_v_q;
	logic [2:0]  rd_cnt_q;
	side_t       rd_side_q;
	logic [15:0] rd_ym_q;
	logic signed [31:0] img1_q, grd1_q;

	logic               yv;
	logic signed [33:0] yval;
	logic [YTW-1:0]     ytag;
	logic [1:0]         ycol;
	side_t              yside;
	logic signed [33:0] p0_q, p1_q, p2_q;

	logic signed [34:0] d20_c, d31_c, d21_c, h20_c, h31_c, k1_c, k2_c;
	logic               xp_v_q;
	logic signed [34:0] xp_p1_q, xp_p2_q, xp_k1_q, xp_k2_q;
	side_t              xp_side_q;

	logic               xv;
	logic signed [36:0] xval;
	logic [SB-1:0]      xtag;
	side_t              xside;
	logic signed [37:0] sum_c;
	logic signed [31:0] sat_c;

	logic signed [31:0] fsum_q [FDEPTH];
	logic               fok_q  [FDEPTH];
	logic [FPW-1:0]     fwp_q, frp_q;
	logic [FCW-1:0]     fcnt_q, resv_q;
	logic               push, pop, reserve;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_sin  <= '0;
			cfg_q.rot_cos  <= 21'sd65536;
			cfg_q.shift_x  <= '0;
			cfg_q.shift_y  <= '0;
			cfg_q.wrap_row <= '0;
			cfg_q.out_rows <= 11'd256;
			cfg_q.out_cols <= 11'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROT_SIN:  cfg_q.rot_sin  <= cfg_data[20:0];
				CFG_ROT_COS:  cfg_q.rot_cos  <= cfg_data[20:0];
				CFG_SHIFT_X:  cfg_q.shift_x  <= cfg_data[27:0];
				CFG_SHIFT_Y:  cfg_q.shift_y  <= cfg_data[27:0];
				CFG_WRAP_ROW: cfg_q.wrap_row <= cfg_data[8:0];
				CFG_OUT_ROWS: cfg_q.out_rows <= cfg_data[10:0];
				CFG_OUT_COLS: cfg_q.out_cols <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	rsw_coord #(
		.IMG_ROWS     (IMG_ROWS),
		.IMG_COLS     (IMG_COLS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_coord (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (req_valid),
		.in_stall     (req_stall),
		.cmd          (cmd),
		.sample_addr  (sample_addr),
		.sample_value (sample_value),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.accum_in     (accum_in),
		.out_valid    (it_v),
		.out_item     (it),
		.out_wdata    (it_wd),
		.take         (take)
	);

	// read sequencer
	assign is_pix  = (it.cmd == CMD_PIX);
	assign credit  = (resv_q < FCW'(FDEPTH));
	assign issue   = it_v && is_pix && ((cnt_q != '0) || credit);
	assign take    = it_v && (!is_pix || (issue && (cnt_q == RD_LAST)));
	assign reserve = take && is_pix;
	assign we_img  = it_v && (it.cmd == CMD_IMG);
	assign we_grd  = it_v && (it.cmd == CMD_GRD);
	assign raddr_c = (cnt_q[0] ? it.base2 : it.base1) + {14'd0, cnt_q[2:1]};
	assign img_addr = we_img ? it.addr : raddr_c;
	assign grd_addr = we_grd ? it.addr : raddr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= issue;
			if (issue) cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_cnt_q  <= cnt_q;
			rd_ym_q   <= it.ym;
			rd_side_q <= '{accum: it.accum, ok: it.ok, v0: it.v0, v3: it.v3, xm: it.xm};
		end
	end

	rsw_ram #(.W(SAMPLE_WIDTH), .DEPTH(STORE_DEPTH)) u_img (
		.clk   (clk),
		.we    (we_img),
		.addr  (img_addr),
		.wdata (it_wd),
		.rdata (img_rdata)
	);

	rsw_ram #(.W(SAMPLE_WIDTH), .DEPTH(STORE_DEPTH)) u_grd (
		.clk   (clk),
		.we    (we_grd),
		.addr  (grd_addr),
		.wdata (it_wd),
		.rdata (grd_rdata)
	);

	assign img_rd = 32'($signed(img_rdata));
	assign grd_rd = 32'($signed(grd_rdata));

	always_ff @(posedge clk) begin
		if (rd_v_q && !rd_cnt_q[0]) begin
			img1_q <= img_rd;
			grd1_q <= grd_rd;
		end
	end

	// splines in y, one per column
	rsw_herm #(.VW(32), .TW(YTW)) u_yherm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_v_q && rd_cnt_q[0]),
		.y1        (img1_q),
		.y2        (img_rd),
		.k1        (grd1_q),
		.k2        (grd_rd),
		.t         (rd_ym_q),
		.tag_in    ({rd_cnt_q[2:1], rd_side_q}),
		.out_valid (yv),
		.value     (yval),
		.tag_out   (ytag)
	);

	assign ycol  = ytag[YTW-1 -: 2];
	assign yside = side_t'(ytag[SB-1:0]);

	// x slopes, one-sided at the column edges
	assign d20_c = 35'(p2_q) - 35'(p0_q);
	assign d31_c = 35'(yval) - 35'(p1_q);
	assign d21_c = 35'(p2_q) - 35'(p1_q);
	assign h20_c = d20_c >>> 1;
	assign h31_c = d31_c >>> 1;
	assign k1_c  = yside.v0 ? h20_c : d21_c;
	assign k2_c  = yside.v3 ? h31_c : d21_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xp_v_q <= 1'b0;
		end else begin
			xp_v_q <= yv && (ycol == 2'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (yv) begin
			case (ycol)
				2'd0: p0_q <= yval;
				2'd1: p1_q <= yval;
				2'd2: p2_q <= yval;
				default: begin
					xp_p1_q   <= 35'(p1_q);
					xp_p2_q   <= 35'(p2_q);
					xp_k1_q   <= k1_c;
					xp_k2_q   <= k2_c;
					xp_side_q <= yside;
				end
			endcase
		end
	end

	// spline in x
	rsw_herm #(.VW(35), .TW(SB)) u_xherm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xp_v_q),
		.y1        (xp_p1_q),
		.y2        (xp_p2_q),
		.k1        (xp_k1_q),
		.k2        (xp_k2_q),
		.t         (xp_side_q.xm),
		.tag_in    (xp_side_q),
		.out_valid (xv),
		.value     (xval),
		.tag_out   (xtag)
	);

	assign xside = side_t'(xtag);
	assign sum_c = 38'(xval) + 38'(xside.accum);

	always_comb begin
		if (sum_c > SUM_MAX) begin
			sat_c = 32'(SUM_MAX);
		end else if (sum_c < SUM_MIN) begin
			sat_c = 32'(SUM_MIN);
		end else begin
			sat_c = sum_c[31:0];
		end
	end

	// output queue
	assign push = xv;
	assign pop  = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwp_q  <= '0;
			frp_q  <= '0;
			fcnt_q <= '0;
			resv_q <= '0;
		end else begin
			if (push) fwp_q <= fwp_q + FPW'(1);
			if (pop)  frp_q <= frp_q + FPW'(1);
			fcnt_q <= fcnt_q + FCW'(push) - FCW'(pop);
			resv_q <= resv_q + FCW'(reserve) - FCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fsum_q[fwp_q] <= xside.ok ? sat_c : xside.accum;
			fok_q[fwp_q]  <= xside.ok;
		end
	end

	assign rsp_valid = (fcnt_q != '0);
	assign pixel_sum = fsum_q[frp_q];
	assign in_range  = fok_q[frp_q];
endmodule
`default_nettype wire

### tb/sv/tb_rotate_shift_wrap_spline_interp_top.sv
// ----------------------------------------------------------------------------
// tb_rotate_shift_wrap_spline_interp_top
// Self-checking bench for the rotated, shifted, row-wrapped Hermite resampler.
// Store entries a compute reads that are still unwritten are written just before it.
// A directed set of writes and computes runs first, followed by random
// traffic under several register settings, the extremes included. The
// sender works in bursts and the receiver stalls on its own pattern. A
// scoreboard class predicts every pixel result and compares it, field by
// field, with each response transaction.
// ----------------------------------------------------------------------------
module tb_rotate_shift_wrap_spline_interp_top;
	import rsw_pkg::*;

	localparam int NROWS = IMG_ROWS_DEF;
	localparam int NCOLS = IMG_COLS_DEF;
	localparam int WDOG_LIMIT = 4000;

	typedef struct {
		logic signed [31:0] sum;
		logic               ok;
	} pix_res_t;

	class pixel_scoreboard;
		int img [STORE_DEPTH];
		int grd [STORE_DEPTH];
		bit img_wr [STORE_DEPTH];
		bit grd_wr [STORE_DEPTH];
		int wr_list [$];
		int need_q [$];
		longint r_sin, r_cos, sh_x, sh_y, wrap, o_rows, o_cols;
		pix_res_t pending [$];
		int errors;

		function new();
			r_sin = 0; r_cos = 65536; sh_x = 0; sh_y = 0;
			wrap = 0; o_rows = 256; o_cols = 256;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
			case (idx)
				CFG_ROT_SIN:  r_sin = longint'($signed(d[20:0]));
				CFG_ROT_COS:  r_cos = longint'($signed(d[20:0]));
				CFG_SHIFT_X:  sh_x = longint'($signed(d[27:0]));
				CFG_SHIFT_Y:  sh_y = longint'($signed(d[27:0]));
				CFG_WRAP_ROW: wrap = longint'(d[8:0]);
				CFG_OUT_ROWS: o_rows = longint'(d[10:0]);
				CFG_OUT_COLS: o_cols = longint'(d[10:0]);
				default: ;
			endcase
		endfunction

		function longint hermite(longint y1, longint y2, longint k1, longint k2,
			longint t);
			longint u, d, a, b, lin, inner, tt;
			u = 65536 - t;
			d = y2 - y1;
			a = k1 - d;
			b = d - k2;
			lin = (y1 * u + y2 * t) >>> 16;
			inner = (a * u + b * t) >>> 16;
			tt = (t * u) >>> 16;
			return lin + ((inner * tt) >>> 16);
		endfunction

		// source position of an output pixel, returns 1 when it lies inside
		function bit locate(logic [9:0] row, logic [9:0] col, output longint x1,
			output longint r1, output longint r2, output longint xm,
			output longint ym);
			longint xq, yq, xs, ys;
			xq = (2 * longint'(col) - o_cols + 1) * 32768;
			yq = (2 * longint'(row) - o_rows + 1) * 32768;
			xs = ((r_cos * xq + r_sin * yq) >>> 16) + NCOLS * 32768 - 32768 - sh_x;
			ys = ((r_cos * yq - r_sin * xq) >>> 16) + NROWS * 32768 - 32768 - sh_y
				+ wrap * 65536;
			x1 = xs >>> 16;
			r1 = ys >>> 16;
			xm = xs & 64'hFFFF;
			ym = ys & 64'hFFFF;
			if (r1 >= NROWS)
				r1 -= NROWS;
			r2 = (r1 + 1 == NROWS) ? 0 : r1 + 1;
			return !(r1 < 0 || r1 >= NROWS || x1 < 0 || x1 + 1 >= NCOLS);
		endfunction

		// store addresses a compute reads, left in need_q
		function void find_reads(logic [9:0] row, logic [9:0] col);
			longint x1, r1, r2, xm, ym, cc;
			need_q.delete();
			if (!locate(row, col, x1, r1, r2, xm, ym))
				return;
			for (int i = 0; i < 4; i++) begin
				cc = x1 - 1 + i;
				if (cc >= 0 && cc < NCOLS) begin
					need_q.push_back(int'((r1 * NCOLS + cc) & 64'hFFFF));
					need_q.push_back(int'((r2 * NCOLS + cc) & 64'hFFFF));
				end
			end
		endfunction

		function bit all_written();
			foreach (need_q[i])
				if (!img_wr[need_q[i]] || !grd_wr[need_q[i]])
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_input(cmd_t c, logic [15:0] ad, logic signed [31:0] v,
			logic [9:0] row, logic [9:0] col, logic signed [31:0] acc);
			longint x1, r1, r2, xm, ym, k1, k2, s, cc;
			longint p [4];
			bit vld [4];
			int a1, a2;
			pix_res_t r;
			if (c == CMD_IMG || c == CMD_GRD) begin
				if (!img_wr[ad] && !grd_wr[ad])
					wr_list.push_back(int'(ad));
				if (c == CMD_IMG) begin
					img[ad] = v;
					img_wr[ad] = 1'b1;
				end else begin
					grd[ad] = v;
					grd_wr[ad] = 1'b1;
				end
				return;
			end
			if (c != CMD_PIX)
				return;
			r.ok = locate(row, col, x1, r1, r2, xm, ym);
			if (r.ok) begin
				for (int i = 0; i < 4; i++) begin
					cc = x1 - 1 + i;
					vld[i] = (cc >= 0 && cc < NCOLS);
					p[i] = 0;
					if (vld[i]) begin
						a1 = int'((r1 * NCOLS + cc) & 64'hFFFF);
						a2 = int'((r2 * NCOLS + cc) & 64'hFFFF);
						p[i] = hermite(img[a1], img[a2], grd[a1], grd[a2], ym);
					end
				end
				k1 = vld[0] ? (p[2] - p[0]) >>> 1 : p[2] - p[1];
				k2 = vld[3] ? (p[3] - p[1]) >>> 1 : p[2] - p[1];
				s = longint'(acc) + hermite(p[1], p[2], k1, k2, xm);
				if (s > 64'sd2147483647) s = 64'sd2147483647;
				if (s < -64'sd2147483648) s = -64'sd2147483648;
				r.sum = s[31:0];
			end else begin
				r.sum = acc;
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [31:0] sum, logic ok);
			pix_res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result sum=%0d in_range=%0b", sum, ok);
				return;
			end
			e = pending.pop_front();
			if (sum !== e.sum || ok !== e.ok) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected sum=%0d in_range=%0b, got sum=%0d in_range=%0b",
						e.sum, e.ok, sum, ok);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic req_valid, req_stall;
	logic [1:0] cmd;
	logic [15:0] sample_addr;
	logic signed [31:0] sample_value;
	logic [9:0] pixel_row, pixel_col;
	logic signed [31:0] accum_in;
	logic rsp_valid, rsp_stall;
	logic signed [31:0] pixel_sum;
	logic in_range;

	pixel_scoreboard sb;
	int burst_left;
	int idle_cycles;
	int stall_mode, stall_left, mode_left;

	rotate_shift_wrap_spline_interp_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall),
		.cmd(cmd), .sample_addr(sample_addr), .sample_value(sample_value),
		.pixel_row(pixel_row), .pixel_col(pixel_col), .accum_in(accum_in),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.pixel_sum(pixel_sum), .in_range(in_range)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic send_req(cmd_t c, logic [15:0] ad, logic signed [31:0] v,
		logic [9:0] row, logic [9:0] col, logic signed [31:0] acc);
		int gap;
		cmd <= c;
		sample_addr <= ad;
		sample_value <= v;
		pixel_row <= row;
		pixel_col <= col;
		accum_in <= acc;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_input(c, ad, v, row, col, acc);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(20, 0);
			gap = $urandom_range(6, 0);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, longint v);
		cfg_index <= idx;
		cfg_data <= v[CFG_DW-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, v[CFG_DW-1:0]);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic load_regs(longint s, longint c, longint sx, longint sy,
		longint w, longint nr, longint nc);
		write_reg(CFG_ROT_SIN, s);
		write_reg(CFG_ROT_COS, c);
		write_reg(CFG_SHIFT_X, sx);
		write_reg(CFG_SHIFT_Y, sy);
		write_reg(CFG_WRAP_ROW, w);
		write_reg(CFG_OUT_ROWS, nr);
		write_reg(CFG_OUT_COLS, nc);
	endtask

	function automatic logic signed [31:0] rand_sample();
		if ($urandom_range(9, 0) == 0)
			return $urandom();
		return $signed($urandom_range(2097152, 0)) - 1048576;
	endfunction

	function automatic logic signed [31:0] rand_accum();
		case ($urandom_range(5, 0))
			0: return 32'sh7FFFFF00 + $urandom_range(255, 0);
			1: return 32'sh80000000 + $urandom_range(255, 0);
			2: return $urandom();
			default: return $signed($urandom_range(2097152, 0)) - 1048576;
		endcase
	endfunction

	// writes every entry the compute reads that is still unwritten, then sends it
	task automatic send_pix(logic [9:0] row, logic [9:0] col, logic signed [31:0] acc);
		int ad;
		sb.find_reads(row, col);
		foreach (sb.need_q[i]) begin
			ad = sb.need_q[i];
			if (!sb.img_wr[ad])
				send_req(CMD_IMG, 16'(ad), rand_sample(), '0, '0, '0);
			if (!sb.grd_wr[ad])
				send_req(CMD_GRD, 16'(ad), rand_sample(), '0, '0, '0);
		end
		send_req(CMD_PIX, 16'($urandom()), $urandom(), row, col, acc);
	endtask

	task automatic random_traffic(int n, int ar, int ac);
		int k, ad;
		logic [9:0] row, col, far_row, far_col;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99, 0);
			if (k < 60) begin
				row = 10'(ar + int'($urandom_range(1, 0)));
				col = 10'(ac + int'($urandom_range(1, 0)));
				if ($urandom_range(3, 0) == 0) begin
					far_row = 10'($urandom());
					far_col = 10'($urandom());
					sb.find_reads(far_row, far_col);
					if (sb.all_written()) begin
						row = far_row;
						col = far_col;
					end
				end
				send_pix(row, col, rand_accum());
			end else if (k < 95) begin
				if (k < 80 && sb.wr_list.size() != 0)
					ad = sb.wr_list[$urandom_range(sb.wr_list.size() - 1, 0)];
				else
					ad = int'($urandom_range(65535, 0));
				send_req(k[0] ? CMD_IMG : CMD_GRD, 16'(ad), rand_sample(),
					10'($urandom()), 10'($urandom()), $urandom());
			end else begin
				send_req(CMD_NOP, 16'($urandom()), $urandom(), 10'($urandom()),
					10'($urandom()), $urandom());
			end
		end
	endtask

	// receiver: stall pattern switches between free-running, random and long runs
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_result(pixel_sum, in_range);
		if (mode_left == 0) begin
			stall_mode = $urandom_range(2, 0);
			mode_left = $urandom_range(200, 20);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= $urandom_range(1, 0);
			default: begin
				if (stall_left == 0)
					stall_left = $urandom_range(20, 1);
				stall_left--;
				rsp_stall <= (stall_left > stall_left / 2 + 3);
			end
		endcase
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (cfg_valid && cfg_ready)
			|| (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		sb = new();
		burst_left = 0;
		idle_cycles = 0;
		stall_mode = 0;
		stall_left = 0;
		mode_left = 0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_valid <= 1'b0;
		rsp_stall <= 1'b0;
		cmd <= CMD_NOP;
		sample_addr <= '0;
		sample_value <= '0;
		pixel_row <= '0;
		pixel_col <= '0;
		accum_in <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, store ends, grid corners, saturation
		send_req(CMD_IMG, 16'h0000, 32'sh7FFFFFFF, '0, '0, '0);
		send_req(CMD_GRD, 16'hFFFF, 32'sh80000000, 10'h3FF, 10'h3FF, 32'sh7FFFFFFF);
		send_req(CMD_NOP, 16'hFFFF, 32'shFFFFFFFF, 10'h3FF, 10'h3FF, 32'shFFFFFFFF);
		send_pix(10'd0, 10'd0, 32'sh7FFFFF00);
		send_pix(10'd255, 10'd255, 32'sh7FFFFFFF);
		send_pix(10'd0, 10'd255, 32'sh80000000);
		send_pix(10'd255, 10'd0, 32'sd65536);
		send_pix(10'd128, 10'd128, -32'sd65536);
		send_pix(10'd1023, 10'd1023, 32'sd1);
		send_pix(10'd1023, 10'd0, 32'sd2);
		drain();
		// half-pixel shift: left and right column edges, row wrap
		load_regs(0, 65536, 32768, 32768, 200, 256, 256);
		send_pix(10'd100, 10'd1, 32'sd0);
		send_pix(10'd100, 10'd255, 32'sd0);
		send_pix(10'd56, 10'd128, 32'sd0);
		send_pix(10'd100, 10'd0, 32'sd0);
		drain();
		// maximum row shift takes rows below zero
		load_regs(0, 65536, -32768, 134217727, 256, 1, 1);
		send_pix(10'd0, 10'd0, 32'sd5);
		send_pix(10'd1023, 10'd512, 32'sd5);
		drain();

		load_regs(0, 65536, 0, 0, 0, 256, 256);
		random_traffic(40, 100, 100);
		drain();
		load_regs(524288, -524288, -134217728, 134217727, 256, 1024, 1);
		random_traffic(25, 500, 0);
		drain();
		load_regs(-524288, 524288, 134217727, -134217728, 0, 1, 1024);
		random_traffic(25, 0, 500);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			load_regs(longint'($signed($urandom_range(140000, 0)) - 70000),
				longint'($signed($urandom_range(140000, 0)) - 70000),
				longint'($signed($urandom_range(8388608, 0)) - 4194304),
				longint'($signed($urandom_range(8388608, 0)) - 4194304),
				longint'($urandom_range(256, 0)), longint'($urandom_range(1024, 1)),
				longint'($urandom_range(1024, 1)));
			random_traffic(25, int'($urandom_range(254, 0)),
				int'($urandom_range(254, 0)));
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
